@@ hdl/br90_pkg.sv @@
// Shared constants, codes and types for the 90-degree bitmap rotator.
`timescale 1ns / 1ps

package br90_pkg;

    // Field widths of the item channels.
    localparam int ADDR_W = 13;
    localparam int BYTE_W = 8;

    // Width of the image size registers.
    localparam int SIDE_W = 9;

    // Default depth of the pixel store in bytes.
    localparam int STORE_BYTES_DEF = 8192;

    // Largest image side honored; larger register values are clamped.
    localparam int MAX_SIDE = 256;

    // Operation codes carried by a command transaction.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_WIDTH     = 2'd0;
    localparam logic [1:0] REG_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_DIRECTION = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_GATHER = 4'b0100,
        ST_DONE   = 4'b1000
    } br90_state_t;

endpackage

@@ hdl/br90_if.sv @@
// Command and result channel interfaces of the bitmap rotator.
`timescale 1ns / 1ps

interface br90_cmd_if;
    import br90_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0] write_byte;

    modport source (output valid, output operation, output byte_address,
                    output write_byte, input ready);
    modport sink   (input valid, input operation, input byte_address,
                    input write_byte, output ready);
endinterface

interface br90_res_if;
    import br90_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rotated_byte;

    modport source (output valid, output rotated_byte, input ready);
    modport sink   (input valid, input rotated_byte, output ready);
endinterface

@@ hdl/bitmap_rotate_90_unit.sv @@
// Top level of the 90-degree rotator for packed 1-bit images.
`timescale 1ns / 1ps

//  Channel | Direction | Contents
//  --------+-----------+-------------------------------------------------
//  cmd     | in        | operation, byte_address, write_byte
//  res     | out       | rotated_byte, one per read command
//  apb     | in/out    | image_width, image_height, rotate_direction
//
//  A write command goes straight into the pixel store.
//  A read command holds the input while the radix-4 divider splits the first pixel index
//  into rotated row and column, the sequencer issues 8 store reads (one per pixel on the
//  single read port), the result is loaded and the sequencer returns to idle.
//  Reset clears the sequencer, the size and direction registers and the result valid, not the pixel store.
//  A finished byte waits in the last state while the previous one still waits on res.ready.

module bitmap_rotate_90_unit #(
    parameter int STORE_BYTES = br90_pkg::STORE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    br90_cmd_if.sink    cmd,
    br90_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import br90_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int LIN_W = 2 * SIDE_W;
    localparam int PIX_W = ADDR_W + 3;

    // Configuration registers.
    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic              dir_reg;

    // Sequencer and datapath registers.
    br90_state_t       state_reg;
    logic [2:0]        div_cnt_reg;
    logic [PIX_W-1:0]  row_reg;
    logic [SIDE_W-1:0] col_reg;
    logic [3:0]        issue_cnt_reg;
    logic [3:0]        col_cnt_reg;
    logic              s1_vld_reg;
    logic              s1_pix_reg;
    logic [LIN_W-1:0]  s1_lin_reg;
    logic              s2_vld_reg;
    logic              s2_pix_reg;
    logic [2:0]        s2_sel_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] gather_reg;
    logic              res_vld_reg;
    logic [BYTE_W-1:0] res_data_reg;

    logic [BYTE_W-1:0] store_mem [STORE_BYTES];

    logic [SIDE_W-1:0] w_eff;
    logic [SIDE_W-1:0] h_eff;
    logic [PIX_W-1:0]  row_next;
    logic [SIDE_W-1:0] rem_next;
    logic              cmd_acc;
    logic              cfg_wr;
    logic              wr_en;
    logic [AW-1:0]     wr_idx;
    logic              rd_en;
    logic [AW-1:0]     rd_idx;
    logic              pix_ok;
    logic [SIDE_W-1:0] src_row;
    logic [SIDE_W-1:0] src_col;
    logic [LIN_W-1:0]  lin_next;
    logic [LIN_W-4:0]  lin_byte;
    logic              in_store;
    logic [SIDE_W:0]   col_inc;
    logic              gather_bit;
    logic              res_load;

    // Size registers as used: zero means one, large values clamp.
    always_comb
    begin
        w_eff = width_reg;
        h_eff = height_reg;
        if (width_reg == '0)
            w_eff = SIDE_W'(1);
        else if (32'(width_reg) > MAX_SIDE)
            w_eff = SIDE_W'(MAX_SIDE);
        if (height_reg == '0)
            h_eff = SIDE_W'(1);
        else if (32'(height_reg) > MAX_SIDE)
            h_eff = SIDE_W'(MAX_SIDE);
    end

    // Register port: writes in the access phase, reads decoded by index.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:     prdata = {23'b0, width_reg};
            REG_HEIGHT:    prdata = {23'b0, height_reg};
            REG_DIRECTION: prdata = {31'b0, dir_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIDE_W'(1);
            height_reg <= SIDE_W'(1);
            dir_reg    <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_WIDTH:     width_reg  <= pwdata[SIDE_W-1:0];
                REG_HEIGHT:    height_reg <= pwdata[SIDE_W-1:0];
                REG_DIRECTION: dir_reg    <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // Command handshake and store write decode.
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign wr_en     = cmd_acc && (cmd.operation == OP_WRITE) &&
                       (32'(cmd.byte_address) < STORE_BYTES);
    assign wr_idx    = AW'({4'b0, cmd.byte_address});

    // Two restoring division steps per cycle: first pixel index over height.
    always_comb
    begin
        logic [PIX_W-1:0]  d;
        logic [SIDE_W-1:0] r;
        logic [SIDE_W:0]   t;
        d = row_reg;
        r = col_reg;
        for (int i = 0; i < 2; i++)
        begin
            t = {r, d[PIX_W-1]};
            d = {d[PIX_W-2:0], 1'b0};
            if (t >= {1'b0, h_eff})
            begin
                t = t - {1'b0, h_eff};
                d[0] = 1'b1;
            end
            r = t[SIDE_W-1:0];
        end
        row_next = d;
        rem_next = r;
    end

    // Issue stage: map rotated row and column to a source pixel index.
    always_comb
    begin
        pix_ok = (row_reg < PIX_W'(w_eff));
        if (dir_reg)
        begin
            src_row = h_eff - SIDE_W'(1) - col_reg;
            src_col = row_reg[SIDE_W-1:0];
        end
        else
        begin
            src_row = col_reg;
            src_col = w_eff - SIDE_W'(1) - row_reg[SIDE_W-1:0];
        end
        lin_next = LIN_W'(src_row) * LIN_W'(w_eff) + LIN_W'(src_col);
        col_inc  = {1'b0, col_reg} + (SIDE_W + 1)'(1);
    end

    // Read stage: the byte that holds the pixel, if it lies in the store.
    assign lin_byte = s1_lin_reg[LIN_W-1:3];
    assign in_store = (32'(lin_byte) < STORE_BYTES);
    assign rd_en    = s1_vld_reg && s1_pix_reg && in_store;
    assign rd_idx   = AW'({1'b0, lin_byte});

    // Pixel store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_idx] <= cmd.write_byte;
        if (rd_en)
            rd_data_reg <= store_mem[rd_idx];
    end

    // Collect stage: pick the pixel bit, padding reads as zero.
    assign gather_bit = s2_pix_reg ? rd_data_reg[~s2_sel_reg] : 1'b0;
    assign res_load   = (state_reg == ST_DONE) && (!res_vld_reg || res.ready);

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            col_cnt_reg   <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= s1_vld_reg;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_acc && (cmd.operation == OP_READ))
                    begin
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    div_cnt_reg <= div_cnt_reg + 3'd1;
                    if (div_cnt_reg == 3'd7)
                    begin
                        issue_cnt_reg <= '0;
                        col_cnt_reg   <= '0;
                        state_reg     <= ST_GATHER;
                    end
                end
                ST_GATHER:
                begin
                    if (!issue_cnt_reg[3])
                    begin
                        issue_cnt_reg <= issue_cnt_reg + 4'd1;
                        s1_vld_reg    <= 1'b1;
                    end
                    if (s2_vld_reg)
                    begin
                        col_cnt_reg <= col_cnt_reg + 4'd1;
                        if (col_cnt_reg == 4'd7)
                            state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (res_load)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (cmd_acc && (cmd.operation == OP_READ))
        begin
            row_reg <= {cmd.byte_address, 3'b000};
            col_reg <= '0;
        end
        else if (state_reg == ST_DIVIDE)
        begin
            row_reg <= row_next;
            col_reg <= rem_next;
        end
        else if ((state_reg == ST_GATHER) && !issue_cnt_reg[3])
        begin
            if (col_inc == {1'b0, h_eff})
            begin
                col_reg <= '0;
                row_reg <= row_reg + PIX_W'(1);
            end
            else
            begin
                col_reg <= col_inc[SIDE_W-1:0];
            end
        end

        s1_pix_reg <= pix_ok;
        s1_lin_reg <= lin_next;
        s2_pix_reg <= s1_pix_reg && in_store;
        s2_sel_reg <= s1_lin_reg[2:0];

        if (s2_vld_reg)
            gather_reg <= {gather_reg[BYTE_W-2:0], gather_bit};
        if (res_load)
            res_data_reg <= gather_reg;
    end

    // Result output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (res_load)
            res_vld_reg <= 1'b1;
        else if (res.ready)
            res_vld_reg <= 1'b0;
    end

    assign res.valid        = res_vld_reg;
    assign res.rotated_byte = res_data_reg;

    // The rotated column stays below the height while pixels are issued.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GATHER) |-> (col_reg < h_eff))
        else $error("rotated column out of range");

    // No pixel is collected that was not issued.
    a_collect_order: assert property (@(posedge clk) disable iff (!rst_n)
        (col_cnt_reg <= issue_cnt_reg))
        else $error("collected more pixels than issued");

    // Read data is consumed only in the cycle after a read was issued.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> $past(s1_vld_reg))
        else $error("collect stage without issued read");

    // A finished byte always reaches the output register.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (res.valid && (state_reg == ST_IDLE)))
        else $error("finished byte not presented");

endmodule
